### sv/pnz_pkg.sv
// Shared types and constants of the 3D gradient noise unit.
package pnz_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int ADDR_W      = 8;
  localparam int DATA_W      = 8;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
  } tbl_wr_t;

endpackage

### sv/pnz_ram.sv
// Permutation table copy: one write port, two registered read ports.
module pnz_ram
  import pnz_pkg::*;
(
  input  logic              clk,
  input  logic              en,
  input  tbl_wr_t           wr,
  input  logic [ADDR_W-1:0] rd_addr_a,
  input  logic [ADDR_W-1:0] rd_addr_b,
  output logic [DATA_W-1:0] rd_data_a,
  output logic [DATA_W-1:0] rd_data_b
);

  logic [DATA_W-1:0] mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (wr.we) begin
        mem[wr.addr] <= wr.data;
      end
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule

### sv/perlin_noise_3d_unit.sv
// Top level of the pipelined 3D gradient noise unit.
//
// Input channel (in_valid/in_stall): in_cmd = 0 loads one permutation table
// entry (in_table_index, in_table_value) and yields no result; in_cmd = 1
// evaluates noise at (in_pos_x, in_pos_y, in_pos_z), signed fixed point with
// FRAC_BITS fraction bits. Every table entry must be loaded before an
// evaluation reads it.
// Output channel (out_valid/out_stall): out_noise, unsigned Q0.16.
// Throughput: one transaction per cycle while in_stall is low, loads and
// evaluations mixed freely; evaluations pass v1_r..v7_r, then out_valid_r.
// The three dependent table lookups run through three levels of table copies
// (one, two and four copies, two read ports each); a load is written into
// each level as it passes that level, so order between loads and
// evaluations is kept exactly. Each blend multiplier is one stage; the fade
// multipliers run through the t2/poly, t3q/polyq and fade3 registers.
// Reset clears all valid flags; table contents stay undefined until loaded.
// When the receiver stalls, the output register holds its transaction and
// the last pipeline stage still fills; in_stall rises only when both are
// occupied, and the whole pipeline then holds.
module perlin_noise_3d_unit
  import pnz_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_cmd,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_pos_z,
  input  logic [7:0]         in_table_index,
  input  logic [7:0]         in_table_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [15:0]        out_noise
);

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_EVAL = 1'b1;

  function automatic logic [15:0] frac_q16(input logic signed [31:0] p);
    logic [23:0] f;
    f = 24'(p[FRAC_BITS-1:0]) << (24 - FRAC_BITS);
    return f[23:8];
  endfunction

  function automatic logic signed [19:0] grad(input logic [7:0] hv,
                                              input logic signed [17:0] x,
                                              input logic signed [17:0] y,
                                              input logic signed [17:0] z);
    logic [3:0] h;
    logic signed [19:0] u, v;
    h = hv[3:0];
    u = (h < 4'd8) ? 20'(x) : 20'(y);
    if (h < 4'd4) v = 20'(y);
    else if (h == 4'd12 || h == 4'd14) v = 20'(x);
    else v = 20'(z);
    return (h[0] ? -u : u) + (h[1] ? -v : v);
  endfunction

  function automatic logic signed [21:0] lerp(input logic [16:0] t,
                                              input logic signed [21:0] a,
                                              input logic signed [21:0] b);
    logic signed [22:0] d;
    logic signed [40:0] p;
    d = 23'(b) - 23'(a);
    p = 41'($signed({1'b0, t})) * 41'(d) + 41'sd32768;
    return a + 22'(p >>> 16);
  endfunction

  logic en;
  logic acc;
  logic [15:0] fin [3];
  logic [7:0]  cx, cy, cz;

  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r, ld1_r, ld2_r;
  logic [7:0]  idx1_r, val1_r, idx2_r, val2_r;
  logic [7:0]  cy1_r, cz1_r, cz2_r;
  logic [15:0] fr1_r [3];
  logic [15:0] fr2_r [3];
  logic [15:0] fr3_r [3];
  logic [31:0] t2_r [3];
  logic signed [39:0] poly_r [3];
  logic [16:0] t3q_r [3];
  logic [20:0] polyq_r [3];
  logic [16:0] fade3_r [3];
  logic [16:0] fade4_r [3];
  logic [16:0] fv5_r, fw5_r, fw6_r;
  logic signed [19:0] g4_r [8];
  logic signed [21:0] l5_r [4];
  logic signed [21:0] m6_r [2];
  logic [15:0] noise7_r;
  logic        out_valid_r;
  logic [15:0] out_noise_r;

  tbl_wr_t wr1, wr2, wr3;
  logic [7:0] l1_da, l1_db;
  logic [7:0] l2_ra [2];
  logic [7:0] l2_rb [2];
  logic [7:0] l2_da [2];
  logic [7:0] l2_db [2];
  logic [7:0] l3_ra [4];
  logic [7:0] l3_rb [4];
  logic [7:0] l3_da [4];
  logic [7:0] l3_db [4];

  logic [31:0] t2_nxt [3];
  logic signed [39:0] poly_nxt [3];
  logic [16:0] t3q_nxt [3];
  logic [20:0] polyq_nxt [3];
  logic [16:0] fade_nxt [3];
  logic signed [19:0] g_nxt [8];
  logic signed [17:0] px [3];
  logic signed [17:0] qx [3];
  logic signed [21:0] n_nxt;
  logic signed [22:0] r_full;
  logic [15:0] noise_nxt;

  assign en       = !(v7_r && out_valid_r && out_stall);
  assign in_stall = !en;
  assign acc      = in_valid && en;

  assign fin[0] = frac_q16(in_pos_x);
  assign fin[1] = frac_q16(in_pos_y);
  assign fin[2] = frac_q16(in_pos_z);
  assign cx = in_pos_x[FRAC_BITS+7:FRAC_BITS];
  assign cy = in_pos_y[FRAC_BITS+7:FRAC_BITS];
  assign cz = in_pos_z[FRAC_BITS+7:FRAC_BITS];

  always_comb begin
    logic signed [21:0] k;
    logic [48:0] t3s;
    logic signed [39:0] pr;
    logic [38:0] fp;
    for (int i = 0; i < 3; i++) begin
      k = 22'sd6 * $signed({6'd0, fin[i]}) - 22'sd983040;
      t2_nxt[i] = 32'(fin[i]) * 32'(fin[i]);
      poly_nxt[i] = 40'($signed({1'b0, fin[i]})) * 40'(k) + 40'sd42949672960;
      t3s = 49'(t2_r[i]) * 49'(fr1_r[i]) + 49'h0_8000_0000;
      t3q_nxt[i] = t3s[48:32];
      pr = (poly_r[i] + 40'sd32768) >>> 16;
      polyq_nxt[i] = pr[20:0];
      fp = 39'(t3q_r[i]) * 39'(polyq_r[i]) + 39'd32768;
      fade_nxt[i] = fp[32:16];
      px[i] = $signed({2'b00, fr3_r[i]});
      qx[i] = px[i] - 18'sd65536;
    end
  end

  assign wr1 = '{we: acc && in_cmd == CMD_LOAD, addr: in_table_index, data: in_table_value};
  assign wr2 = '{we: ld1_r, addr: idx1_r, data: val1_r};
  assign wr3 = '{we: ld2_r, addr: idx2_r, data: val2_r};

  pnz_ram u_l1 (
    .clk(clk), .en(en), .wr(wr1), .rd_addr_a(cx), .rd_addr_b(cx + 8'd1),
    .rd_data_a(l1_da), .rd_data_b(l1_db)
  );

  assign l2_ra[0] = l1_da + cy1_r;
  assign l2_ra[1] = l1_db + cy1_r;
  assign l2_rb[0] = l2_ra[0] + 8'd1;
  assign l2_rb[1] = l2_ra[1] + 8'd1;

  for (genvar i = 0; i < 2; i++) begin : g_l2
    pnz_ram u_ram (
      .clk(clk), .en(en), .wr(wr2), .rd_addr_a(l2_ra[i]), .rd_addr_b(l2_rb[i]),
      .rd_data_a(l2_da[i]), .rd_data_b(l2_db[i])
    );
  end

  // copies: aa, ba, ab, bb
  assign l3_ra[0] = l2_da[0] + cz2_r;
  assign l3_ra[1] = l2_da[1] + cz2_r;
  assign l3_ra[2] = l2_db[0] + cz2_r;
  assign l3_ra[3] = l2_db[1] + cz2_r;

  for (genvar i = 0; i < 4; i++) begin : g_l3
    assign l3_rb[i] = l3_ra[i] + 8'd1;
    pnz_ram u_ram (
      .clk(clk), .en(en), .wr(wr3), .rd_addr_a(l3_ra[i]), .rd_addr_b(l3_rb[i]),
      .rd_data_a(l3_da[i]), .rd_data_b(l3_db[i])
    );
  end

  always_comb begin
    g_nxt[0] = grad(l3_da[0], px[0], px[1], px[2]);
    g_nxt[1] = grad(l3_da[1], qx[0], px[1], px[2]);
    g_nxt[2] = grad(l3_da[2], px[0], qx[1], px[2]);
    g_nxt[3] = grad(l3_da[3], qx[0], qx[1], px[2]);
    g_nxt[4] = grad(l3_db[0], px[0], px[1], qx[2]);
    g_nxt[5] = grad(l3_db[1], qx[0], px[1], qx[2]);
    g_nxt[6] = grad(l3_db[2], px[0], qx[1], qx[2]);
    g_nxt[7] = grad(l3_db[3], qx[0], qx[1], qx[2]);
  end

  always_comb begin
    n_nxt = lerp(fw6_r, m6_r[0], m6_r[1]);
    r_full = (23'(n_nxt) + 23'sd65536) >>> 1;
    if (r_full < 23'sd0) noise_nxt = 16'd0;
    else if (r_full > 23'sd65535) noise_nxt = 16'hFFFF;
    else noise_nxt = r_full[15:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0; v4_r <= 1'b0;
      v5_r <= 1'b0; v6_r <= 1'b0; v7_r <= 1'b0;
      ld1_r <= 1'b0; ld2_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en) begin
        v1_r  <= acc && in_cmd == CMD_EVAL;
        ld1_r <= acc && in_cmd == CMD_LOAD;
        v2_r  <= v1_r;
        ld2_r <= ld1_r;
        v3_r  <= v2_r;
        v4_r  <= v3_r;
        v5_r  <= v4_r;
        v6_r  <= v5_r;
        v7_r  <= v6_r;
        out_valid_r <= v7_r || (out_valid_r && out_stall);
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      idx1_r <= in_table_index; val1_r <= in_table_value;
      idx2_r <= idx1_r;         val2_r <= val1_r;
      cy1_r <= cy; cz1_r <= cz; cz2_r <= cz1_r;
      for (int i = 0; i < 3; i++) begin
        fr1_r[i]   <= fin[i];
        fr2_r[i]   <= fr1_r[i];
        fr3_r[i]   <= fr2_r[i];
        t2_r[i]    <= t2_nxt[i];
        poly_r[i]  <= poly_nxt[i];
        t3q_r[i]   <= t3q_nxt[i];
        polyq_r[i] <= polyq_nxt[i];
        fade3_r[i] <= fade_nxt[i];
        fade4_r[i] <= fade3_r[i];
      end
      for (int i = 0; i < 8; i++) g4_r[i] <= g_nxt[i];
      for (int i = 0; i < 4; i++) begin
        l5_r[i] <= lerp(fade4_r[0], 22'(g4_r[2*i]), 22'(g4_r[2*i+1]));
      end
      fv5_r <= fade4_r[1];
      fw5_r <= fade4_r[2];
      m6_r[0] <= lerp(fv5_r, l5_r[0], l5_r[1]);
      m6_r[1] <= lerp(fv5_r, l5_r[2], l5_r[3]);
      fw6_r <= fw5_r;
      noise7_r <= noise_nxt;
      if (v7_r) out_noise_r <= noise7_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_noise = out_noise_r;

endmodule

### sv/pnz_checker.sv
// Port-level checker for the noise unit, bound to the top level.
module pnz_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] out_noise
);

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a blocked output");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid)
    else $error("output transaction dropped under stall");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> $stable(out_noise))
    else $error("output payload changed under stall");

endmodule

bind perlin_noise_3d_unit pnz_checker u_pnz_checker (
  .clk(clk), .rst_n(rst_n), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_noise(out_noise)
);
